[design/http_request_header_parser_assert.svh]
// Assertion macros used by the parser stage of the HTTP request header parser RTL.
`ifndef HTTP_REQUEST_HEADER_PARSER_ASSERT_SVH
`define HTTP_REQUEST_HEADER_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define HRHP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define HRHP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/hrhp_pkg.sv]
// Types, constants and helper functions of the HTTP request header parser.
package hrhp_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned COUNT_W     = 17;
   localparam int unsigned LEN_W       = 5;
   localparam int unsigned POS_W       = 6;
   localparam int unsigned EVENT_W     = 4;
   localparam int unsigned METHOD_W    = 3;
   localparam int unsigned ERROR_W     = 2;
   localparam int unsigned VERB_COUNT  = 8;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 17;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [POS_W-1:0]   POS_MAX   = '1;

   localparam logic [COUNT_W-1:0] MAX_REQUEST_BYTES_RST = 17'h10000;
   localparam logic [LEN_W-1:0]   MAX_METHOD_LENGTH_RST = 5'd20;
   localparam logic [LEN_W-1:0]   MAX_KEY_LENGTH_RST    = 5'd31;
   localparam logic [VERB_COUNT-1:0] CANDIDATES_RST     = '1;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_REQUEST_BYTES = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_METHOD_LENGTH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_KEY_LENGTH    = 2'd2;

   localparam logic [EVENT_W-1:0] EV_NONE          = 4'd0;
   localparam logic [EVENT_W-1:0] EV_RESOURCE_BYTE = 4'd1;
   localparam logic [EVENT_W-1:0] EV_RESOURCE_END  = 4'd2;
   localparam logic [EVENT_W-1:0] EV_LINE_END      = 4'd3;
   localparam logic [EVENT_W-1:0] EV_KEY_BYTE      = 4'd4;
   localparam logic [EVENT_W-1:0] EV_KEY_END       = 4'd5;
   localparam logic [EVENT_W-1:0] EV_VALUE_BYTE    = 4'd6;
   localparam logic [EVENT_W-1:0] EV_VALUE_END     = 4'd7;
   localparam logic [EVENT_W-1:0] EV_COMPLETE      = 4'd8;
   localparam logic [EVENT_W-1:0] EV_ERROR         = 4'd9;

   localparam logic [ERROR_W-1:0] ERR_NONE        = 2'd0;
   localparam logic [ERROR_W-1:0] ERR_MALFORMED   = 2'd1;
   localparam logic [ERROR_W-1:0] ERR_UNSUPPORTED = 2'd2;
   localparam logic [ERROR_W-1:0] ERR_TOO_LONG    = 2'd3;

   localparam logic [BYTE_W-1:0] CH_SPACE      = 8'h20;
   localparam logic [BYTE_W-1:0] CH_DOT        = 8'h2E;
   localparam logic [BYTE_W-1:0] CH_SLASH      = 8'h2F;
   localparam logic [BYTE_W-1:0] CH_ZERO       = 8'h30;
   localparam logic [BYTE_W-1:0] CH_ONE        = 8'h31;
   localparam logic [BYTE_W-1:0] CH_NINE       = 8'h39;
   localparam logic [BYTE_W-1:0] CH_COLON      = 8'h3A;
   localparam logic [BYTE_W-1:0] CH_DASH       = 8'h2D;
   localparam logic [BYTE_W-1:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [BYTE_W-1:0] CH_UPPER_A    = 8'h41;
   localparam logic [BYTE_W-1:0] CH_UPPER_Z    = 8'h5A;
   localparam logic [BYTE_W-1:0] CH_LOWER_A    = 8'h61;
   localparam logic [BYTE_W-1:0] CH_LOWER_Z    = 8'h7A;
   localparam logic [BYTE_W-1:0] CH_CR         = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF         = 8'h0A;
   localparam logic [BYTE_W-1:0] CONTROL_LIMIT = 8'h20;
   localparam logic [BYTE_W-1:0] CASE_OFFSET   = 8'h20;

   // Method names, left-justified and padded with spaces to eight characters.
   localparam logic [63:0] VERB_TEXT [VERB_COUNT] = '{
      "GET     ", "POST    ", "HEAD    ", "PUT     ",
      "DELETE  ", "OPTIONS ", "CONNECT ", "BREW    "
   };
   localparam logic [2:0] VERB_LEN [VERB_COUNT] = '{
      3'd3, 3'd4, 3'd4, 3'd3, 3'd6, 3'd7, 3'd7, 3'd4
   };
   localparam logic [47:0]      VERSION_TEXT = "HTTP/1";
   localparam logic [POS_W-1:0] VERSION_LEN  = 6'd6;

   typedef enum logic [3:0] {
      PH_METHOD,
      PH_RESOURCE,
      PH_VERSION,
      PH_MINOR,
      PH_LINE_LF,
      PH_KEY,
      PH_SPACES,
      PH_VALUE,
      PH_FINAL_LF
   } phase_type;

   typedef struct packed {
      logic [COUNT_W-1:0] max_request_bytes;
      logic [LEN_W-1:0]   max_method_length;
      logic [LEN_W-1:0]   max_key_length;
   } cfg_type;

   typedef struct packed {
      logic [EVENT_W-1:0]  event_res;
      logic [BYTE_W-1:0]   data;
      logic [METHOD_W-1:0] method;
      logic                minor_version;
      logic [ERROR_W-1:0]  error_code;
      logic [COUNT_W-1:0]  request_length;
   } result_type;

   function automatic logic is_upper(input logic [BYTE_W-1:0] b);
      return (b >= CH_UPPER_A) && (b <= CH_UPPER_Z);
   endfunction

   // Lowercase letters, digits, dash and underscore pass into a key as they are.
   function automatic logic is_key_char(input logic [BYTE_W-1:0] b);
      return ((b >= CH_LOWER_A) && (b <= CH_LOWER_Z)) ||
             ((b >= CH_ZERO) && (b <= CH_NINE)) ||
             (b == CH_DASH) || (b == CH_UNDERSCORE);
   endfunction

   function automatic logic [BYTE_W-1:0] verb_char(input logic [2:0] k, input logic [2:0] i);
      return VERB_TEXT[k][{~i, 3'b000} +: BYTE_W];
   endfunction

   // Valid for positions below the length of the version prefix.
   function automatic logic [BYTE_W-1:0] version_char(input logic [2:0] i);
      logic [2:0] rev;
      rev = 3'd5 - i;
      return VERSION_TEXT[{rev, 3'b000} +: BYTE_W];
   endfunction

endpackage

[design/hrhp_req_if.sv]
// Request byte channel: one request byte and a restart flag per beat.
interface hrhp_req_if;
   logic                          valid;
   logic                          ready;
   logic [hrhp_pkg::BYTE_W-1:0]   byte_value;
   logic                          restart;

   modport source (output valid, output byte_value, output restart, input ready);
   modport sink   (input valid, input byte_value, input restart, output ready);
endinterface

[design/hrhp_rsp_if.sv]
// Token event channel: one parser event and status per beat.
interface hrhp_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [hrhp_pkg::EVENT_W-1:0]    event_res;
   logic [hrhp_pkg::BYTE_W-1:0]     data;
   logic [hrhp_pkg::METHOD_W-1:0]   method;
   logic                            minor_version;
   logic [hrhp_pkg::ERROR_W-1:0]    error_code;
   logic [hrhp_pkg::COUNT_W-1:0]    request_length;

   modport source (output valid, output event_res, output data, output method,
                   output minor_version, output error_code, output request_length,
                   input ready);
   modport sink   (input valid, input event_res, input data, input method,
                   input minor_version, input error_code, input request_length,
                   output ready);
endinterface

[design/hrhp_csr.sv]
// Configuration registers of the parser: limits on length and token sizes.
module hrhp_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [hrhp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [hrhp_pkg::CSR_DATA_W-1:0]    csr_write_data,
   output hrhp_pkg::cfg_type                  cfg
);

   hrhp_pkg::cfg_type cfg_ff;
   hrhp_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            hrhp_pkg::CSR_MAX_REQUEST_BYTES: begin
               cfg_in.max_request_bytes = csr_write_data[hrhp_pkg::COUNT_W-1:0];
            end
            hrhp_pkg::CSR_MAX_METHOD_LENGTH: begin
               cfg_in.max_method_length = csr_write_data[hrhp_pkg::LEN_W-1:0];
            end
            hrhp_pkg::CSR_MAX_KEY_LENGTH: begin
               cfg_in.max_key_length = csr_write_data[hrhp_pkg::LEN_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_request_bytes <= hrhp_pkg::MAX_REQUEST_BYTES_RST;
         cfg_ff.max_method_length <= hrhp_pkg::MAX_METHOD_LENGTH_RST;
         cfg_ff.max_key_length    <= hrhp_pkg::MAX_KEY_LENGTH_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[design/hrhp_parser.sv]
// Parser state and the per-byte update that produces one token event.
`include "http_request_header_parser_assert.svh"

module hrhp_parser (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           fire,
   input  logic [hrhp_pkg::BYTE_W-1:0]    byte_value,
   input  logic                           restart,
   input  hrhp_pkg::cfg_type              cfg,
   output hrhp_pkg::result_type           result
);

   hrhp_pkg::phase_type                 phase_ff, phase_in;
   logic [hrhp_pkg::POS_W-1:0]          pos_ff, pos_in;
   logic [hrhp_pkg::VERB_COUNT-1:0]     cand_ff, cand_in;
   logic                                vok_ff, vok_in;
   logic [hrhp_pkg::METHOD_W-1:0]       method_ff, method_in;
   logic                                minor_ff, minor_in;
   logic [hrhp_pkg::COUNT_W-1:0]        count_ff, count_in;
   logic [hrhp_pkg::ERROR_W-1:0]        error_ff, error_in;

   hrhp_pkg::phase_type                 cur_phase, step_phase;
   logic [hrhp_pkg::POS_W-1:0]          cur_pos, step_pos, pos_inc;
   logic [hrhp_pkg::VERB_COUNT-1:0]     cur_cand, step_cand, len_mask;
   logic                                cur_vok, step_vok;
   logic [hrhp_pkg::METHOD_W-1:0]       cur_method, step_method;
   logic                                cur_minor, step_minor;
   logic [hrhp_pkg::COUNT_W-1:0]        cur_count, step_count;
   logic [hrhp_pkg::ERROR_W-1:0]        cur_error, step_error, err;
   logic [hrhp_pkg::EVENT_W-1:0]        ev;
   logic [hrhp_pkg::BYTE_W-1:0]         data;
   logic                                done;

   // Restart takes effect before the byte is looked at.
   always_comb begin
      if (restart) begin
         cur_phase  = hrhp_pkg::PH_METHOD;
         cur_pos    = '0;
         cur_cand   = hrhp_pkg::CANDIDATES_RST;
         cur_vok    = 1'b1;
         cur_method = '0;
         cur_minor  = 1'b0;
         cur_count  = '0;
         cur_error  = hrhp_pkg::ERR_NONE;
      end else begin
         cur_phase  = phase_ff;
         cur_pos    = pos_ff;
         cur_cand   = cand_ff;
         cur_vok    = vok_ff;
         cur_method = method_ff;
         cur_minor  = minor_ff;
         cur_count  = count_ff;
         cur_error  = error_ff;
      end
   end

   assign pos_inc = (cur_pos == hrhp_pkg::POS_MAX) ? cur_pos : cur_pos + 1'b1;

   always_comb begin
      for (int k = 0; k < hrhp_pkg::VERB_COUNT; k++) begin
         len_mask[k] = ({3'b000, hrhp_pkg::VERB_LEN[k]} == cur_pos);
      end
   end

   always_comb begin
      step_phase  = cur_phase;
      step_pos    = cur_pos;
      step_cand   = cur_cand;
      step_vok    = cur_vok;
      step_method = cur_method;
      step_minor  = cur_minor;
      step_count  = cur_count;
      step_error  = cur_error;
      err         = hrhp_pkg::ERR_NONE;
      ev          = hrhp_pkg::EV_NONE;
      data        = '0;
      done        = 1'b0;

      if (cur_error != hrhp_pkg::ERR_NONE) begin
         ev = hrhp_pkg::EV_ERROR;
      end else begin
         if (cur_count != hrhp_pkg::COUNT_MAX) begin
            step_count = cur_count + 1'b1;
         end
         if (step_count > cfg.max_request_bytes) begin
            err = hrhp_pkg::ERR_TOO_LONG;
         end else begin
            unique case (cur_phase)
               hrhp_pkg::PH_METHOD: begin
                  if (byte_value == hrhp_pkg::CH_SPACE) begin
                     if (cur_pos > {1'b0, cfg.max_method_length}) begin
                        err = hrhp_pkg::ERR_MALFORMED;
                     end else begin
                        step_cand   = cur_cand & len_mask;
                        // The lowest surviving candidate names the method.
                        step_method = '0;
                        for (int k = hrhp_pkg::VERB_COUNT - 1; k >= 0; k--) begin
                           if (step_cand[k]) begin
                              step_method = k[hrhp_pkg::METHOD_W-1:0];
                           end
                        end
                        step_phase = hrhp_pkg::PH_RESOURCE;
                        step_pos   = '0;
                     end
                  end else if (hrhp_pkg::is_upper(byte_value)) begin
                     for (int k = 0; k < hrhp_pkg::VERB_COUNT; k++) begin
                        if ((cur_pos >= {3'b000, hrhp_pkg::VERB_LEN[k]}) ||
                            (hrhp_pkg::verb_char(k[2:0], cur_pos[2:0]) != byte_value)) begin
                           step_cand[k] = 1'b0;
                        end
                     end
                     step_pos = pos_inc;
                  end else begin
                     err = hrhp_pkg::ERR_MALFORMED;
                  end
               end
               hrhp_pkg::PH_RESOURCE: begin
                  if (byte_value == hrhp_pkg::CH_SPACE) begin
                     if (cur_cand == '0) begin
                        err = hrhp_pkg::ERR_UNSUPPORTED;
                     end else begin
                        ev         = hrhp_pkg::EV_RESOURCE_END;
                        step_phase = hrhp_pkg::PH_VERSION;
                        step_pos   = '0;
                        step_vok   = 1'b1;
                     end
                  end else if (byte_value < hrhp_pkg::CONTROL_LIMIT) begin
                     err = hrhp_pkg::ERR_MALFORMED;
                  end else begin
                     ev   = hrhp_pkg::EV_RESOURCE_BYTE;
                     data = byte_value;
                  end
               end
               hrhp_pkg::PH_VERSION: begin
                  if (byte_value == hrhp_pkg::CH_DOT) begin
                     if ((cur_pos != hrhp_pkg::VERSION_LEN) || !cur_vok) begin
                        err = hrhp_pkg::ERR_MALFORMED;
                     end else begin
                        step_phase = hrhp_pkg::PH_MINOR;
                        step_pos   = '0;
                     end
                  end else if (hrhp_pkg::is_upper(byte_value) ||
                               (byte_value == hrhp_pkg::CH_SLASH) ||
                               (byte_value == hrhp_pkg::CH_ONE)) begin
                     if ((cur_pos >= hrhp_pkg::VERSION_LEN) ||
                         (hrhp_pkg::version_char(cur_pos[2:0]) != byte_value)) begin
                        step_vok = 1'b0;
                     end
                     step_pos = pos_inc;
                  end else begin
                     err = hrhp_pkg::ERR_MALFORMED;
                  end
               end
               hrhp_pkg::PH_MINOR: begin
                  if ((byte_value == hrhp_pkg::CH_LF) || (byte_value == hrhp_pkg::CH_CR)) begin
                     if (cur_pos == '0) begin
                        err = hrhp_pkg::ERR_MALFORMED;
                     end else if (byte_value == hrhp_pkg::CH_LF) begin
                        ev         = hrhp_pkg::EV_LINE_END;
                        step_phase = hrhp_pkg::PH_KEY;
                        step_pos   = '0;
                     end else begin
                        step_phase = hrhp_pkg::PH_LINE_LF;
                     end
                  end else if (((byte_value == hrhp_pkg::CH_ZERO) ||
                                (byte_value == hrhp_pkg::CH_ONE)) && (cur_pos == '0)) begin
                     step_minor = byte_value[0];
                     step_pos   = pos_inc;
                  end else begin
                     err = hrhp_pkg::ERR_MALFORMED;
                  end
               end
               hrhp_pkg::PH_LINE_LF: begin
                  if (byte_value == hrhp_pkg::CH_LF) begin
                     ev         = hrhp_pkg::EV_LINE_END;
                     step_phase = hrhp_pkg::PH_KEY;
                     step_pos   = '0;
                  end else begin
                     err = hrhp_pkg::ERR_MALFORMED;
                  end
               end
               hrhp_pkg::PH_KEY: begin
                  if (byte_value == hrhp_pkg::CH_COLON) begin
                     ev         = hrhp_pkg::EV_KEY_END;
                     step_phase = hrhp_pkg::PH_SPACES;
                  end else if ((cur_pos == '0) && (byte_value == hrhp_pkg::CH_LF)) begin
                     ev   = hrhp_pkg::EV_COMPLETE;
                     done = 1'b1;
                  end else if ((cur_pos == '0) && (byte_value == hrhp_pkg::CH_CR)) begin
                     step_phase = hrhp_pkg::PH_FINAL_LF;
                  end else if (cur_pos >= {1'b0, cfg.max_key_length}) begin
                     err = hrhp_pkg::ERR_MALFORMED;
                  end else if (hrhp_pkg::is_upper(byte_value)) begin
                     ev       = hrhp_pkg::EV_KEY_BYTE;
                     data     = byte_value + hrhp_pkg::CASE_OFFSET;
                     step_pos = pos_inc;
                  end else if (hrhp_pkg::is_key_char(byte_value)) begin
                     ev       = hrhp_pkg::EV_KEY_BYTE;
                     data     = byte_value;
                     step_pos = pos_inc;
                  end else begin
                     err = hrhp_pkg::ERR_MALFORMED;
                  end
               end
               hrhp_pkg::PH_SPACES: begin
                  // The first byte after the spaces joins the value unchecked.
                  if (byte_value != hrhp_pkg::CH_SPACE) begin
                     ev         = hrhp_pkg::EV_VALUE_BYTE;
                     data       = byte_value;
                     step_phase = hrhp_pkg::PH_VALUE;
                  end
               end
               hrhp_pkg::PH_VALUE: begin
                  if (byte_value >= hrhp_pkg::CONTROL_LIMIT) begin
                     ev   = hrhp_pkg::EV_VALUE_BYTE;
                     data = byte_value;
                  end else if (byte_value == hrhp_pkg::CH_LF) begin
                     ev         = hrhp_pkg::EV_VALUE_END;
                     step_phase = hrhp_pkg::PH_KEY;
                     step_pos   = '0;
                  end else if (byte_value == hrhp_pkg::CH_CR) begin
                     ev         = hrhp_pkg::EV_VALUE_END;
                     step_phase = hrhp_pkg::PH_LINE_LF;
                  end else begin
                     err = hrhp_pkg::ERR_MALFORMED;
                  end
               end
               hrhp_pkg::PH_FINAL_LF: begin
                  if (byte_value == hrhp_pkg::CH_LF) begin
                     ev   = hrhp_pkg::EV_COMPLETE;
                     done = 1'b1;
                  end else begin
                     err = hrhp_pkg::ERR_MALFORMED;
                  end
               end
               default: begin
                  err = hrhp_pkg::ERR_MALFORMED;
               end
            endcase
         end
         if (err != hrhp_pkg::ERR_NONE) begin
            step_error = err;
            ev         = hrhp_pkg::EV_ERROR;
            data       = '0;
         end
      end
   end

   always_comb begin
      result.event_res      = ev;
      result.data           = data;
      result.method         = step_method;
      result.minor_version  = step_minor;
      result.error_code     = step_error;
      result.request_length = step_count;
   end

   // A completed request leaves everything but the error at its reset value.
   always_comb begin
      error_in = step_error;
      if (done) begin
         phase_in  = hrhp_pkg::PH_METHOD;
         pos_in    = '0;
         cand_in   = hrhp_pkg::CANDIDATES_RST;
         vok_in    = 1'b1;
         method_in = '0;
         minor_in  = 1'b0;
         count_in  = '0;
      end else begin
         phase_in  = step_phase;
         pos_in    = step_pos;
         cand_in   = step_cand;
         vok_in    = step_vok;
         method_in = step_method;
         minor_in  = step_minor;
         count_in  = step_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= hrhp_pkg::PH_METHOD;
         pos_ff    <= '0;
         cand_ff   <= hrhp_pkg::CANDIDATES_RST;
         vok_ff    <= 1'b1;
         method_ff <= '0;
         minor_ff  <= 1'b0;
         count_ff  <= '0;
         error_ff  <= hrhp_pkg::ERR_NONE;
      end else if (fire) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         cand_ff   <= cand_in;
         vok_ff    <= vok_in;
         method_ff <= method_in;
         minor_ff  <= minor_in;
         count_ff  <= count_in;
         error_ff  <= error_in;
      end
   end

   `HRHP_ASSERT_NOW(a_error_event_matches_code, clock, reset, fire, ((result.error_code != hrhp_pkg::ERR_NONE) == (result.event_res == hrhp_pkg::EV_ERROR)), "error code and error event disagree")
   `HRHP_ASSERT_NEXT(a_latched_error_freezes_count, clock, reset, fire && !restart && (error_ff != hrhp_pkg::ERR_NONE), (count_ff == $past(count_ff)) && (error_ff == $past(error_ff)), "byte counted while an error is latched")
   `HRHP_ASSERT_NEXT(a_complete_clears_state, clock, reset, fire && (result.event_res == hrhp_pkg::EV_COMPLETE), (phase_ff == hrhp_pkg::PH_METHOD) && (count_ff == '0) && (pos_ff == '0), "parse state not cleared after a complete request")
   `HRHP_ASSERT_NEXT(a_restart_clears_error, clock, reset, fire && restart && (result.event_res != hrhp_pkg::EV_ERROR), error_ff == hrhp_pkg::ERR_NONE, "restart did not clear the latched error")

endmodule

[design/http_request_header_parser.sv]
// A request byte is held in the input register; its token event is held in the result register.
// Throughput: one byte per cycle while the receiver does not stall; the parser state update sets that bound.
// The input register and the result register advance together when the result is free.
// Reset is synchronous and active high: both beat registers empty, parse state and
// latched error cleared, limits back to 65536 bytes, 20 method and 31 key characters.
module http_request_header_parser (
   input  logic                               clock,
   input  logic                               reset,
   hrhp_req_if.sink                           req_channel,
   hrhp_rsp_if.source                         rsp_channel,
   input  logic                               csr_write_enable,
   input  logic [hrhp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [hrhp_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   hrhp_pkg::cfg_type             cfg;
   hrhp_pkg::result_type          result;

   logic                          in_valid_ff, in_valid_in;
   logic [hrhp_pkg::BYTE_W-1:0]   in_byte_ff;
   logic                          in_restart_ff;
   logic                          out_valid_ff, out_valid_in;
   hrhp_pkg::result_type          out_payload_ff;
   logic                          advance;
   logic                          take;

   hrhp_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   hrhp_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .fire       (advance),
      .byte_value (in_byte_ff),
      .restart    (in_restart_ff),
      .cfg        (cfg),
      .result     (result)
   );

   // A held beat moves into the result register whenever that register is free
   // or being drained in the same cycle.
   assign advance           = in_valid_ff && (!out_valid_ff || rsp_channel.ready);
   assign req_channel.ready = !in_valid_ff || advance;
   assign take              = req_channel.valid && req_channel.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_channel.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_byte_ff    <= req_channel.byte_value;
         in_restart_ff <= req_channel.restart;
      end
      if (advance) begin
         out_payload_ff <= result;
      end
   end

   assign rsp_channel.valid          = out_valid_ff;
   assign rsp_channel.event_res      = out_payload_ff.event_res;
   assign rsp_channel.data           = out_payload_ff.data;
   assign rsp_channel.method         = out_payload_ff.method;
   assign rsp_channel.minor_version  = out_payload_ff.minor_version;
   assign rsp_channel.error_code     = out_payload_ff.error_code;
   assign rsp_channel.request_length = out_payload_ff.request_length;

endmodule

[verif/http_request_header_parser_tb.sv]
// Self-checking testbench for the HTTP request header parser: request byte streams vs. a predictor.
module http_request_header_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import hrhp_pkg::*;

   localparam int IDLE_LIMIT = 10000;

   // Predicts the token event of every accepted request byte and checks the results.
   class token_event_tracker;
      string                method_names[VERB_COUNT];
      string                version_prefix;
      logic [COUNT_W-1:0]   max_request_bytes;
      logic [LEN_W-1:0]     max_method_length;
      logic [LEN_W-1:0]     max_key_length;
      phase_type            phase;
      logic [POS_W-1:0]     token_pos;
      logic [VERB_COUNT-1:0] candidates;
      logic                 version_ok;
      logic [METHOD_W-1:0]  method_code;
      logic                 minor_digit;
      logic [COUNT_W-1:0]   byte_count;
      logic [ERROR_W-1:0]   error_code;
      result_type           pending_events[$];
      int                   mismatch_count;

      function new();
         method_names = '{"GET", "POST", "HEAD", "PUT", "DELETE", "OPTIONS", "CONNECT", "BREW"};
         version_prefix = "HTTP/1";
         mismatch_count = 0;
         clear_request();
         error_code = ERR_NONE;
         max_request_bytes = MAX_REQUEST_BYTES_RST;
         max_method_length = MAX_METHOD_LENGTH_RST;
         max_key_length = MAX_KEY_LENGTH_RST;
      endfunction

      function void clear_request();
         phase = PH_METHOD;
         token_pos = '0;
         candidates = '1;
         version_ok = 1'b1;
         method_code = '0;
         minor_digit = 1'b0;
         byte_count = '0;
      endfunction

      function void set_limit(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_MAX_REQUEST_BYTES: max_request_bytes = value;
            CSR_MAX_METHOD_LENGTH: max_method_length = value[LEN_W-1:0];
            CSR_MAX_KEY_LENGTH:    max_key_length = value[LEN_W-1:0];
            default: ;
         endcase
      endfunction

      function bit error_latched();
         return error_code != ERR_NONE;
      endfunction

      function void note_request_byte(logic [BYTE_W-1:0] b, logic restart);
         logic [EVENT_W-1:0]    ev;
         logic [BYTE_W-1:0]     data;
         logic [ERROR_W-1:0]    err;
         logic [VERB_COUNT-1:0] mask;
         bit                    done;
         result_type            r;
         ev = EV_NONE;
         data = '0;
         err = ERR_NONE;
         done = 0;
         if (restart) begin
            clear_request();
            error_code = ERR_NONE;
         end
         if (error_code != ERR_NONE) begin
            ev = EV_ERROR;
         end else begin
            if (byte_count != '1) byte_count++;
            if (byte_count > max_request_bytes) begin
               err = ERR_TOO_LONG;
            end else begin
               case (phase)
                  PH_METHOD: begin
                     if (b == CH_SPACE) begin
                        if (token_pos > max_method_length) begin
                           err = ERR_MALFORMED;
                        end else begin
                           mask = '0;
                           for (int k = 0; k < VERB_COUNT; k++)
                              if (method_names[k].len() == token_pos && candidates[k]) mask[k] = 1'b1;
                           candidates = mask;
                           // The lowest surviving candidate names the method.
                           method_code = '0;
                           for (int k = VERB_COUNT - 1; k >= 0; k--)
                              if (mask[k]) method_code = k[METHOD_W-1:0];
                           phase = PH_RESOURCE;
                           token_pos = '0;
                        end
                     end else if (b >= CH_UPPER_A && b <= CH_UPPER_Z) begin
                        for (int k = 0; k < VERB_COUNT; k++)
                           if (token_pos >= method_names[k].len() || method_names[k][token_pos] != b)
                              candidates[k] = 1'b0;
                        if (token_pos != POS_MAX) token_pos++;
                     end else begin
                        err = ERR_MALFORMED;
                     end
                  end
                  PH_RESOURCE: begin
                     if (b == CH_SPACE) begin
                        if (candidates == '0) begin
                           err = ERR_UNSUPPORTED;
                        end else begin
                           ev = EV_RESOURCE_END;
                           phase = PH_VERSION;
                           token_pos = '0;
                           version_ok = 1'b1;
                        end
                     end else if (b < CONTROL_LIMIT) begin
                        err = ERR_MALFORMED;
                     end else begin
                        ev = EV_RESOURCE_BYTE;
                        data = b;
                     end
                  end
                  PH_VERSION: begin
                     if (b == CH_DOT) begin
                        if (token_pos != VERSION_LEN || !version_ok) begin
                           err = ERR_MALFORMED;
                        end else begin
                           phase = PH_MINOR;
                           token_pos = '0;
                        end
                     end else if ((b >= CH_UPPER_A && b <= CH_UPPER_Z) || b == CH_SLASH ||
                                  b == CH_ONE) begin
                        if (token_pos >= VERSION_LEN || version_prefix[token_pos] != b)
                           version_ok = 1'b0;
                        if (token_pos != POS_MAX) token_pos++;
                     end else begin
                        err = ERR_MALFORMED;
                     end
                  end
                  PH_MINOR: begin
                     if (b == CH_LF || b == CH_CR) begin
                        if (token_pos == '0) begin
                           err = ERR_MALFORMED;
                        end else if (b == CH_LF) begin
                           ev = EV_LINE_END;
                           phase = PH_KEY;
                           token_pos = '0;
                        end else begin
                           phase = PH_LINE_LF;
                        end
                     end else if ((b == CH_ZERO || b == CH_ONE) && token_pos == '0) begin
                        minor_digit = b[0];
                        token_pos = 6'd1;
                     end else begin
                        err = ERR_MALFORMED;
                     end
                  end
                  PH_LINE_LF: begin
                     if (b == CH_LF) begin
                        ev = EV_LINE_END;
                        phase = PH_KEY;
                        token_pos = '0;
                     end else begin
                        err = ERR_MALFORMED;
                     end
                  end
                  PH_KEY: begin
                     if (b == CH_COLON) begin
                        ev = EV_KEY_END;
                        phase = PH_SPACES;
                     end else if (token_pos == '0 && b == CH_LF) begin
                        ev = EV_COMPLETE;
                        done = 1;
                     end else if (token_pos == '0 && b == CH_CR) begin
                        phase = PH_FINAL_LF;
                     end else if (token_pos >= max_key_length) begin
                        err = ERR_MALFORMED;
                     end else if (b >= CH_UPPER_A && b <= CH_UPPER_Z) begin
                        ev = EV_KEY_BYTE;
                        data = b + CASE_OFFSET;
                        token_pos++;
                     end else if ((b >= CH_LOWER_A && b <= CH_LOWER_Z) ||
                                  (b >= CH_ZERO && b <= CH_NINE) ||
                                  b == CH_DASH || b == CH_UNDERSCORE) begin
                        ev = EV_KEY_BYTE;
                        data = b;
                        token_pos++;
                     end else begin
                        err = ERR_MALFORMED;
                     end
                  end
                  PH_SPACES: begin
                     // The first byte after the spaces joins the value unchecked.
                     if (b != CH_SPACE) begin
                        ev = EV_VALUE_BYTE;
                        data = b;
                        phase = PH_VALUE;
                     end
                  end
                  PH_VALUE: begin
                     if (b >= CONTROL_LIMIT) begin
                        ev = EV_VALUE_BYTE;
                        data = b;
                     end else if (b == CH_LF) begin
                        ev = EV_VALUE_END;
                        phase = PH_KEY;
                        token_pos = '0;
                     end else if (b == CH_CR) begin
                        ev = EV_VALUE_END;
                        phase = PH_LINE_LF;
                     end else begin
                        err = ERR_MALFORMED;
                     end
                  end
                  PH_FINAL_LF: begin
                     if (b == CH_LF) begin
                        ev = EV_COMPLETE;
                        done = 1;
                     end else begin
                        err = ERR_MALFORMED;
                     end
                  end
                  default: err = ERR_MALFORMED;
               endcase
            end
            if (err != ERR_NONE) begin
               error_code = err;
               ev = EV_ERROR;
               data = '0;
            end
         end
         r.event_res = ev;
         r.data = data;
         r.method = method_code;
         r.minor_version = minor_digit;
         r.error_code = error_code;
         r.request_length = byte_count;
         pending_events.push_back(r);
         if (done) clear_request();
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] seen);
         if (seen !== want) begin
            $error("%s: expected %0h, got %0h", field, want, seen);
            mismatch_count++;
         end
      endfunction

      function void check_token_event(result_type seen);
         result_type want;
         if (pending_events.size() == 0) begin
            $error("token event %0h arrived with none expected", seen.event_res);
            mismatch_count++;
            return;
         end
         want = pending_events.pop_front();
         compare_field("event_res", want.event_res, seen.event_res);
         compare_field("data", want.data, seen.data);
         compare_field("method", want.method, seen.method);
         compare_field("minor_version", want.minor_version, seen.minor_version);
         compare_field("error_code", want.error_code, seen.error_code);
         compare_field("request_length", want.request_length, seen.request_length);
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;
   int                     sender_idle_pct = 0;
   int                     receiver_stall_pct = 0;
   int                     bytes_sent = 0;
   int                     quiet_cycles = 0;
   logic [BYTE_W-1:0]      request_bytes[$];
   token_event_tracker     tracker = new();

   hrhp_req_if req_bus();
   hrhp_rsp_if rsp_bus();

   http_request_header_parser u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_channel      (req_bus),
      .rsp_channel      (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin : check_results
      result_type seen;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen.event_res = rsp_bus.event_res;
         seen.data = rsp_bus.data;
         seen.method = rsp_bus.method;
         seen.minor_version = rsp_bus.minor_version;
         seen.error_code = rsp_bus.error_code;
         seen.request_length = rsp_bus.request_length;
         tracker.check_token_event(seen);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_byte(input logic [BYTE_W-1:0] value, input logic restart_flag);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.byte_value <= value;
      req_bus.restart <= restart_flag;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      tracker.note_request_byte(value, restart_flag);
      bytes_sent++;
   endtask

   task automatic send_text(input string text, input bit restart_first);
      for (int i = 0; i < text.len(); i++) send_byte(text[i], restart_first && i == 0);
   endtask

   task automatic program_limit(input logic [CSR_INDEX_W-1:0] index,
                                input logic [CSR_DATA_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= value;
      @(posedge clock);
      tracker.set_limit(index, value);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // Holds the sender back until every predicted token event has been seen.
   task automatic drain_pipeline();
      req_bus.valid <= 1'b0;
      while (tracker.pending_events.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic void push_text(input string text);
      for (int i = 0; i < text.len(); i++) request_bytes.push_back(text[i]);
   endfunction

   function automatic void push_line_end();
      if ($urandom_range(1) == 1) request_bytes.push_back(CH_CR);
      request_bytes.push_back(CH_LF);
   endfunction

   function automatic logic [BYTE_W-1:0] key_char();
      case ($urandom_range(3))
         0: return 8'($urandom_range(CH_UPPER_A, CH_UPPER_Z));
         1: return 8'($urandom_range(CH_LOWER_A, CH_LOWER_Z));
         2: return 8'($urandom_range(CH_ZERO, CH_NINE));
         default: return ($urandom_range(1) == 1) ? CH_DASH : CH_UNDERSCORE;
      endcase
   endfunction

   // A mostly well-formed request head with random content; some are damaged on purpose.
   function automatic void compose_request();
      int pick;
      int count;
      request_bytes.delete();
      pick = $urandom_range(99);
      if (pick < 80) begin
         push_text(tracker.method_names[$urandom_range(VERB_COUNT - 1)]);
      end else if (pick < 92) begin
         count = $urandom_range(1, 40);
         repeat (count) request_bytes.push_back(8'($urandom_range(CH_UPPER_A, CH_UPPER_Z)));
      end else if (pick < 96) begin
         count = $urandom_range(1, 5);
         repeat (count) request_bytes.push_back(8'($urandom_range(CH_LOWER_A, CH_LOWER_Z)));
      end
      request_bytes.push_back(CH_SPACE);
      count = $urandom_range(0, 10);
      repeat (count) request_bytes.push_back(8'($urandom_range(CH_SPACE + 1, 255)));
      request_bytes.push_back(CH_SPACE);
      push_text("HTTP/1.");
      if ($urandom_range(29) != 0) request_bytes.push_back(8'($urandom_range(CH_ZERO, CH_ONE)));
      push_line_end();
      repeat ($urandom_range(3)) begin
         count = $urandom_range(0, 8);
         repeat (count) request_bytes.push_back(key_char());
         request_bytes.push_back(CH_COLON);
         repeat ($urandom_range(2)) request_bytes.push_back(CH_SPACE);
         if ($urandom_range(4) == 0) request_bytes.push_back(8'($urandom_range(255)));
         else request_bytes.push_back(8'($urandom_range(CH_SPACE + 1, 255)));
         count = $urandom_range(0, 10);
         repeat (count) request_bytes.push_back(8'($urandom_range(CONTROL_LIMIT, 255)));
         push_line_end();
      end
      push_line_end();
      if ($urandom_range(99) < 12)
         request_bytes[$urandom_range(request_bytes.size() - 1)] = 8'($urandom_range(255));
   endfunction

   task automatic send_request();
      int   tail;
      logic restart_flag;
      compose_request();
      tail = $urandom_range(2);
      for (int i = 0; i < request_bytes.size(); i++) begin
         if (i == 0) restart_flag = tracker.error_latched() || ($urandom_range(7) == 0);
         else restart_flag = ($urandom_range(299) == 0);
         send_byte(request_bytes[i], restart_flag);
         // Up to two bytes after an error show that it stays latched; then move on.
         if (tracker.error_latched()) begin
            if (tail == 0) break;
            tail--;
         end
      end
   endtask

   task automatic apply_setting(input int step);
      case (step)
         1: begin
            program_limit(CSR_MAX_REQUEST_BYTES, 17'h10000);
            program_limit(CSR_MAX_METHOD_LENGTH, 17'd31);
            program_limit(CSR_MAX_KEY_LENGTH, 17'd31);
         end
         2: begin
            program_limit(CSR_MAX_REQUEST_BYTES, 17'd1);
            program_limit(CSR_MAX_METHOD_LENGTH, 17'd1);
            program_limit(CSR_MAX_KEY_LENGTH, 17'd1);
         end
         3: begin
            program_limit(CSR_MAX_REQUEST_BYTES, 17'd60);
            program_limit(CSR_MAX_METHOD_LENGTH, 17'd4);
            program_limit(CSR_MAX_KEY_LENGTH, 17'd5);
         end
         4: begin
            program_limit(CSR_MAX_REQUEST_BYTES, 17'($urandom_range(30, 300)));
            program_limit(CSR_MAX_METHOD_LENGTH, 17'($urandom_range(1, 31)));
            program_limit(CSR_MAX_KEY_LENGTH, 17'($urandom_range(1, 31)));
         end
         5: begin
            program_limit(CSR_MAX_REQUEST_BYTES, 17'h10000);
            program_limit(CSR_MAX_METHOD_LENGTH, 17'd7);
            program_limit(CSR_MAX_KEY_LENGTH, 17'd8);
         end
         default: ;
      endcase
   endtask

   initial begin
      int phase_start;
      req_bus.valid <= 1'b0;
      req_bus.byte_value <= '0;
      req_bus.restart <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_index <= CSR_MAX_REQUEST_BYTES;
      csr_write_data <= '0;
      reset <= 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Key bytes with every allowed class, a high resource byte, CR LF line ends.
      send_text("BREW /", 1);
      send_byte(8'hFF, 1'b0);
      send_text(" HTTP/1.0\r\nX-a_9: v\r\n\r\n", 0);
      // Empty key, a value that starts with LF, bare LF everywhere.
      send_text("PUT * HTTP/1.1\n:\n\n\n", 1);
      // Unknown method reported at the resource end, then one ignored byte.
      send_text("XY a b", 1);
      // Lowercase method.
      send_text("g", 1);

      for (int step = 0; step < 6; step++) begin
         drain_pipeline();
         apply_setting(step);
         case (step % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 74; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 74; end
            default: begin sender_idle_pct = 30; receiver_stall_pct = 30; end
         endcase
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < ((step == 2) ? 40 : 250)) send_request();
      end

      drain_pipeline();
      repeat (8) @(posedge clock);
      if (tracker.mismatch_count == 0 && tracker.pending_events.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
